FILE: rtl/core/saff_pkg.sv
// Shared constants, types and tables of the sprite affine transform block.
// No dependencies; every other file of the block refers to this package by scoped names.
package saff_pkg;

  // Fraction width of positions, scales, matrix terms and sine/cosine.
  localparam int FRAC_BITS     = 16;
  // Number of CORDIC rotation stages.
  localparam int CORDIC_STAGES = 16;

  // Field widths.
  localparam int POS_W = 32;
  localparam int SC_W  = 24;
  localparam int ANG_W = 32;
  localparam int M_W   = 24;
  localparam int T_W   = 32;

  // Angles are always Q16.16 degrees.
  localparam int ANG_FULL    = 23592960;
  localparam int ANG_HALF    = 11796480;
  localparam int ANG_QUARTER = 5898240;
  // Residue of the sign offset 2^(ANG_W-1) modulo a full turn.
  localparam int ANG_OFFSET  = int'((64'd1 << (ANG_W - 1)) % 64'(ANG_FULL));

  // Modulo reduction: eight conditional subtractions, two per pipeline stage.
  localparam int RED_STEPS     = 8;
  localparam int RED_PER_STAGE = 2;
  localparam int RED_STAGES    = RED_STEPS / RED_PER_STAGE;
  localparam int REM_W         = 25;
  localparam int PHI_W         = 26;

  // CORDIC datapath.
  localparam int XY_W    = 32;
  localparam int XY_FRAC = 30;
  localparam int Z_W     = 26;
  localparam int CS_SHIFT = XY_FRAC - FRAC_BITS;
  localparam int CS_W    = XY_W + 1 - CS_SHIFT;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

  localparam int ATAN_W = 22;
  // atan(2^-i) in degrees, Q16.16, rounded to nearest.
  localparam logic [ATAN_W-1:0] ATAN_DEG [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [SC_W-1:0]  scale_x;
    logic signed [SC_W-1:0]  scale_y;
  } saff_geom_t;

  typedef struct packed {
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
  } saff_trig_t;

  typedef struct packed {
    logic signed [M_W-1:0] m_xx;
    logic signed [M_W-1:0] m_xy;
    logic signed [M_W-1:0] m_yx;
    logic signed [M_W-1:0] m_yy;
  } saff_mat_t;

  typedef struct packed {
    saff_mat_t             mat;
    logic signed [T_W-1:0] trans_x;
    logic signed [T_W-1:0] trans_y;
  } saff_result_t;

endpackage

FILE: rtl/core/saff_if.sv
// Request and result channel interfaces of the sprite affine transform block.
// Depends on saff_pkg for the field widths.
interface saff_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [saff_pkg::POS_W-1:0] origin_x;
  logic signed [saff_pkg::POS_W-1:0] origin_y;
  logic signed [saff_pkg::POS_W-1:0] pos_x;
  logic signed [saff_pkg::POS_W-1:0] pos_y;
  logic signed [saff_pkg::SC_W-1:0]  scale_x;
  logic signed [saff_pkg::SC_W-1:0]  scale_y;
  logic signed [saff_pkg::ANG_W-1:0] rotation_deg;

  modport source (output valid, origin_x, origin_y, pos_x, pos_y, scale_x, scale_y,
                  rotation_deg, input ready);
  modport sink (input valid, origin_x, origin_y, pos_x, pos_y, scale_x, scale_y,
                rotation_deg, output ready);
endinterface

interface saff_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [saff_pkg::M_W-1:0] m_xx;
  logic signed [saff_pkg::M_W-1:0] m_xy;
  logic signed [saff_pkg::M_W-1:0] m_yx;
  logic signed [saff_pkg::M_W-1:0] m_yy;
  logic signed [saff_pkg::T_W-1:0] trans_x;
  logic signed [saff_pkg::T_W-1:0] trans_y;

  modport source (output valid, m_xx, m_xy, m_yx, m_yy, trans_x, trans_y, input ready);
  modport sink (input valid, m_xx, m_xy, m_yx, m_yy, trans_x, trans_y, output ready);
endinterface

FILE: rtl/core/sprite_affine_transform.sv
// Top level of the sprite affine transform block: angle reduction, CORDIC and matrix
// pipelines. Depends on saff_pkg, saff_if, saff_angle_reduce, saff_cordic, saff_matrix.
// Throughput: one request per cycle while the result side does not stall; each stage holds
// two steps of the modulo reduction, one CORDIC iteration, one rank of multiplies or adds,
// or one offset, fold or rounding step, so nothing is shared.
// Reset: synchronous, active low, clears the valid bits only; no clearing pass.
module sprite_affine_transform (
  input  logic       clk,
  input  logic       rst_n,
  saff_in_if.sink    in_ch,
  saff_out_if.source out_ch
);

  // The whole pipeline moves as one: every stage advances whenever the result
  // register is empty or its result is being taken. Bubbles travel as cleared
  // valid bits, so a stall on the result side freezes every stage in place and
  // no request is dropped or repeated.
  logic adv;

  saff_pkg::saff_geom_t   in_geom;

  logic                   red_valid;
  logic signed [saff_pkg::PHI_W-1:0] red_phi;
  logic                   red_flip;
  saff_pkg::saff_geom_t   red_geom;

  logic                   cor_valid;
  saff_pkg::saff_trig_t   cor_trig;
  saff_pkg::saff_geom_t   cor_geom;

  logic                   res_valid;
  saff_pkg::saff_result_t res;

  assign adv         = ~res_valid | out_ch.ready;
  assign in_ch.ready = adv;

  // The geometry of the request rides alongside the angle through every stage.
  always_comb begin
    in_geom.origin_x = in_ch.origin_x;
    in_geom.origin_y = in_ch.origin_y;
    in_geom.pos_x    = in_ch.pos_x;
    in_geom.pos_y    = in_ch.pos_y;
    in_geom.scale_x  = in_ch.scale_x;
    in_geom.scale_y  = in_ch.scale_y;
  end

  // Wraps the angle into a full turn, negates it and folds it to within a
  // quarter turn of zero, remembering whether the result must be flipped.
  saff_angle_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_angle (in_ch.rotation_deg),
    .in_geom  (in_geom),
    .out_valid(red_valid),
    .out_phi  (red_phi),
    .out_flip (red_flip),
    .out_geom (red_geom)
  );

  // Sine and cosine of the negated angle.
  saff_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (red_valid),
    .in_phi   (red_phi),
    .in_flip  (red_flip),
    .in_geom  (red_geom),
    .out_valid(cor_valid),
    .out_trig (cor_trig),
    .out_geom (cor_geom)
  );

  // Scaled rotation terms and the saturated translation; its last stage is
  // the result register seen on the result channel.
  saff_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (cor_valid),
    .in_trig  (cor_trig),
    .in_geom  (cor_geom),
    .out_valid(res_valid),
    .out_res  (res)
  );

  assign out_ch.valid   = res_valid;
  assign out_ch.m_xx    = res.mat.m_xx;
  assign out_ch.m_xy    = res.mat.m_xy;
  assign out_ch.m_yx    = res.mat.m_yx;
  assign out_ch.m_yy    = res.mat.m_yy;
  assign out_ch.trans_x = res.trans_x;
  assign out_ch.trans_y = res.trans_y;

  // A held result must stay valid until the pipeline is allowed to move.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(adv) |-> $stable(res_valid))
    else $error("result valid changed while the pipeline was stalled");

endmodule

FILE: rtl/core/saff_angle_reduce.sv
// Angle reduction pipeline: wraps the rotation modulo a full turn and folds the
// negated angle into [-90, 90] degrees with a flip flag. Depends on saff_pkg.
module saff_angle_reduce (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic signed [saff_pkg::ANG_W-1:0]  in_angle,
  input  saff_pkg::saff_geom_t               in_geom,
  output logic                               out_valid,
  output logic signed [saff_pkg::PHI_W-1:0]  out_phi,
  output logic                               out_flip,
  output saff_pkg::saff_geom_t               out_geom
);

  localparam int NS = saff_pkg::RED_STAGES;
  localparam int AW = saff_pkg::ANG_W;
  localparam int PW = saff_pkg::PHI_W;
  localparam int RW = saff_pkg::REM_W;

  localparam logic signed [PW-1:0] FULL_S    = PW'(saff_pkg::ANG_FULL);
  localparam logic signed [PW-1:0] HALF_S    = PW'(saff_pkg::ANG_HALF);
  localparam logic signed [PW-1:0] QUARTER_S = PW'(saff_pkg::ANG_QUARTER);
  localparam logic [RW-1:0]        OFFSET_U  = RW'(saff_pkg::ANG_OFFSET);
  localparam logic [RW-1:0]        WRAP_U    = RW'(saff_pkg::ANG_FULL - saff_pkg::ANG_OFFSET);

  // Full turn scaled by the weight of subtraction step j (largest first).
  function automatic logic [AW-1:0] step_of(input int j);
    return AW'(saff_pkg::ANG_FULL) << (saff_pkg::RED_STEPS - 1 - j);
  endfunction

  logic [AW-1:0]        rem_r   [NS];
  logic [NS-1:0]        vld_r;
  saff_pkg::saff_geom_t geom_r  [NS];

  logic [RW-1:0]        t_nxt, t_r;
  logic                 vf1_r;
  saff_pkg::saff_geom_t gf1_r;

  logic signed [PW-1:0] t_s, phi_a, phi_nxt, phi_r;
  logic                 flip_nxt, flip_r, vf2_r;
  saff_pkg::saff_geom_t gf2_r;

  // The signed angle is offset by 2^31 so the remainder works on an unsigned word.
  for (genvar s = 0; s < NS; s++) begin : g_red
    logic [AW-1:0] src;
    logic [AW-1:0] rem_nxt;
    if (s == 0) begin : g_first
      assign src = {~in_angle[AW-1], in_angle[AW-2:0]};
    end else begin : g_next
      assign src = rem_r[s-1];
    end
    always_comb begin
      rem_nxt = src;
      for (int k = 0; k < saff_pkg::RED_PER_STAGE; k++) begin
        if (rem_nxt >= step_of(s * saff_pkg::RED_PER_STAGE + k)) begin
          rem_nxt = rem_nxt - step_of(s * saff_pkg::RED_PER_STAGE + k);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt;
      end
    end
  end

  // Remove the offset again to get the angle in [0, 360).
  always_comb begin
    if (rem_r[NS-1][RW-1:0] < OFFSET_U) begin
      t_nxt = rem_r[NS-1][RW-1:0] + WRAP_U;
    end else begin
      t_nxt = rem_r[NS-1][RW-1:0] - OFFSET_U;
    end
  end

  // Negate into [-180, 180) and fold into the right half plane.
  always_comb begin
    t_s      = $signed(PW'(t_r));
    phi_a    = (t_s > HALF_S) ? FULL_S - t_s : -t_s;
    phi_nxt  = phi_a;
    flip_nxt = 1'b0;
    if (phi_a > QUARTER_S) begin
      phi_nxt  = phi_a - HALF_S;
      flip_nxt = 1'b1;
    end else if (phi_a < -QUARTER_S) begin
      phi_nxt  = phi_a + HALF_S;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vf1_r <= 1'b0;
      vf2_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
      vf1_r <= vld_r[NS-1];
      vf2_r <= vf1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geom_r[0] <= in_geom;
      for (int s = 1; s < NS; s++) begin
        geom_r[s] <= geom_r[s-1];
      end
      t_r    <= t_nxt;
      gf1_r  <= geom_r[NS-1];
      phi_r  <= phi_nxt;
      flip_r <= flip_nxt;
      gf2_r  <= gf1_r;
    end
  end

  assign out_valid = vf2_r;
  assign out_phi   = phi_r;
  assign out_flip  = flip_r;
  assign out_geom  = gf2_r;

  a_rem_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> (rem_r[NS-1] < AW'(saff_pkg::ANG_FULL)))
    else $error("angle remainder not below a full turn");

  a_phi_folded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (phi_r <= QUARTER_S && phi_r >= -QUARTER_S))
    else $error("folded angle outside the right half plane");

endmodule

FILE: rtl/core/saff_cordic.sv
// Unrolled rotation-mode CORDIC, one iteration per register stage, followed by
// the quadrant flip and rounding of sine and cosine. Depends on saff_pkg.
module saff_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [saff_pkg::PHI_W-1:0] in_phi,
  input  logic                              in_flip,
  input  saff_pkg::saff_geom_t              in_geom,
  output logic                              out_valid,
  output saff_pkg::saff_trig_t              out_trig,
  output saff_pkg::saff_geom_t              out_geom
);

  localparam int N  = saff_pkg::CORDIC_STAGES;
  localparam int XW = saff_pkg::XY_W;
  localparam int ZW = saff_pkg::Z_W;
  localparam int SH = saff_pkg::CS_SHIFT;

  localparam logic signed [XW:0] RND = (XW + 1)'(2 ** (SH - 1));

  logic signed [XW-1:0] x_r [N];
  logic signed [XW-1:0] y_r [N];
  logic signed [ZW-1:0] z_r [N];
  logic [N-1:0]         flip_r;
  logic [N-1:0]         vld_r;
  saff_pkg::saff_geom_t geom_r [N];

  logic signed [XW:0]   x_ext, y_ext, c_sum, s_sum;
  saff_pkg::saff_trig_t trig_nxt, trig_r;
  logic                 ovld_r;
  saff_pkg::saff_geom_t ogeom_r;

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(saff_pkg::ATAN_DEG[i]);
    logic signed [XW-1:0] x_src, y_src, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_src, z_nxt;
    if (i == 0) begin : g_first
      assign x_src = saff_pkg::GAIN_Q30;
      assign y_src = '0;
      assign z_src = ZW'(in_phi);
    end else begin : g_next
      assign x_src = x_r[i-1];
      assign y_src = y_r[i-1];
      assign z_src = z_r[i-1];
    end
    always_comb begin
      if (!z_src[ZW-1]) begin
        x_nxt = x_src - (y_src >>> i);
        y_nxt = y_src + (x_src >>> i);
        z_nxt = z_src - ATAN_I;
      end else begin
        x_nxt = x_src + (y_src >>> i);
        y_nxt = y_src - (x_src >>> i);
        z_nxt = z_src + ATAN_I;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  // Undo the fold, then round half up to the output fraction width.
  always_comb begin
    x_ext = (XW + 1)'(x_r[N-1]);
    y_ext = (XW + 1)'(y_r[N-1]);
    if (flip_r[N-1]) begin
      x_ext = -x_ext;
      y_ext = -y_ext;
    end
    c_sum = x_ext + RND;
    s_sum = y_ext + RND;
    trig_nxt.cos_v = c_sum[XW:SH];
    trig_nxt.sin_v = s_sum[XW:SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= {vld_r[N-2:0], in_valid};
      ovld_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flip_r    <= {flip_r[N-2:0], in_flip};
      geom_r[0] <= in_geom;
      for (int i = 1; i < N; i++) begin
        geom_r[i] <= geom_r[i-1];
      end
      trig_r  <= trig_nxt;
      ogeom_r <= geom_r[N-1];
    end
  end

  assign out_valid = ovld_r;
  assign out_trig  = trig_r;
  assign out_geom  = ogeom_r;

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(adv) |-> (ovld_r == $past(vld_r[N-1])))
    else $error("CORDIC valid bit lost or duplicated");

endmodule

FILE: rtl/core/saff_matrix.sv
// Matrix and translation pipeline: scales sine and cosine, then forms the
// saturated translation from the origin and position. Depends on saff_pkg.
module saff_matrix (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  saff_pkg::saff_trig_t   in_trig,
  input  saff_pkg::saff_geom_t   in_geom,
  output logic                   out_valid,
  output saff_pkg::saff_result_t out_res
);

  localparam int MW = saff_pkg::M_W;
  localparam int TW = saff_pkg::T_W;
  localparam int FB = saff_pkg::FRAC_BITS;
  localparam int PM_W = saff_pkg::SC_W + saff_pkg::CS_W;
  localparam int PT_W = saff_pkg::POS_W + MW;
  localparam int TS_W = ((PT_W > saff_pkg::POS_W + FB) ? PT_W : saff_pkg::POS_W + FB) + 2;

  localparam logic signed [MW-1:0] M_MAX = MW'(2 ** (MW - 1) - 1);
  localparam logic signed [MW-1:0] M_MIN = ~M_MAX;
  localparam logic signed [TW-1:0] T_MAX = TW'(64'(2) ** (TW - 1) - 1);
  localparam logic signed [TW-1:0] T_MIN = ~T_MAX;
  localparam logic signed [PM_W:0] RND_M = (PM_W + 1)'(2 ** (FB - 1));
  localparam logic signed [TS_W:0] RND_T = (TS_W + 1)'(2 ** (FB - 1));

  function automatic logic signed [MW-1:0] rnd_sat_m(input logic signed [PM_W-1:0] p);
    logic signed [PM_W:0] q;
    q = (PM_W + 1)'(p) + RND_M;
    q = q >>> FB;
    if (q > (PM_W + 1)'(M_MAX)) begin
      return M_MAX;
    end else if (q < (PM_W + 1)'(M_MIN)) begin
      return M_MIN;
    end
    return q[MW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] rnd_sat_t(input logic signed [TS_W-1:0] p);
    logic signed [TS_W:0] q;
    q = (TS_W + 1)'(p) + RND_T;
    q = q >>> FB;
    if (q > (TS_W + 1)'(T_MAX)) begin
      return T_MAX;
    end else if (q < (TS_W + 1)'(T_MIN)) begin
      return T_MIN;
    end
    return q[TW-1:0];
  endfunction

  logic [4:0] v_r;

  // Stage 1: scale times sine and cosine.
  logic signed [PM_W-1:0] p_sxc_r, p_syc_r, p_sxs_r, p_sys_r;
  saff_pkg::saff_geom_t   g1_r;
  // Stage 2: rounded, saturated matrix terms.
  saff_pkg::saff_mat_t    mat_nxt, mat2_r;
  logic signed [MW-1:0]   sxs_nxt, sxs2_r;
  saff_pkg::saff_geom_t   g2_r;
  // Stage 3: origin times matrix terms.
  logic signed [PT_W-1:0] q_oxc_r, q_oys_r, q_oxs_r, q_oyc_r;
  saff_pkg::saff_mat_t    mat3_r;
  logic signed [saff_pkg::POS_W-1:0] px3_r, py3_r;
  // Stage 4: full precision translation sums.
  logic signed [TS_W-1:0] tx_nxt, ty_nxt, tx4_r, ty4_r;
  saff_pkg::saff_mat_t    mat4_r;
  // Stage 5: result register.
  saff_pkg::saff_result_t res_r;

  always_comb begin
    sxs_nxt      = rnd_sat_m(p_sxs_r);
    mat_nxt.m_xx = rnd_sat_m(p_sxc_r);
    mat_nxt.m_xy = rnd_sat_m(p_sys_r);
    mat_nxt.m_yy = rnd_sat_m(p_syc_r);
    mat_nxt.m_yx = (sxs_nxt == M_MIN) ? M_MAX : -sxs_nxt;
  end

  always_comb begin
    tx_nxt = (TS_W'(px3_r) <<< FB) - TS_W'(q_oxc_r) - TS_W'(q_oys_r);
    ty_nxt = (TS_W'(py3_r) <<< FB) + TS_W'(q_oxs_r) - TS_W'(q_oyc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sxc_r <= PM_W'($signed(in_geom.scale_x)) * PM_W'($signed(in_trig.cos_v));
      p_syc_r <= PM_W'($signed(in_geom.scale_y)) * PM_W'($signed(in_trig.cos_v));
      p_sxs_r <= PM_W'($signed(in_geom.scale_x)) * PM_W'($signed(in_trig.sin_v));
      p_sys_r <= PM_W'($signed(in_geom.scale_y)) * PM_W'($signed(in_trig.sin_v));
      g1_r    <= in_geom;

      mat2_r <= mat_nxt;
      sxs2_r <= sxs_nxt;
      g2_r   <= g1_r;

      q_oxc_r <= PT_W'($signed(g2_r.origin_x)) * PT_W'($signed(mat2_r.m_xx));
      q_oys_r <= PT_W'($signed(g2_r.origin_y)) * PT_W'($signed(mat2_r.m_xy));
      q_oxs_r <= PT_W'($signed(g2_r.origin_x)) * PT_W'($signed(sxs2_r));
      q_oyc_r <= PT_W'($signed(g2_r.origin_y)) * PT_W'($signed(mat2_r.m_yy));
      mat3_r  <= mat2_r;
      px3_r   <= g2_r.pos_x;
      py3_r   <= g2_r.pos_y;

      tx4_r  <= tx_nxt;
      ty4_r  <= ty_nxt;
      mat4_r <= mat3_r;

      res_r.mat     <= mat4_r;
      res_r.trans_x <= rnd_sat_t(tx4_r);
      res_r.trans_y <= rnd_sat_t(ty4_r);
    end
  end

  assign out_valid = v_r[4];
  assign out_res   = res_r;

  a_myx_negated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (res_r.mat.m_yx != M_MIN))
    else $error("negated sine term reached the negative limit");

endmodule
